>>> rtl/core/swfp_pkg.sv
// Shared types, character codes and frame lengths for the scale weight frame parser.
package swfp_pkg;

    // Store geometry: the first bytes of one reply buffer.
    localparam int unsigned StoreDepth = 17;
    localparam int unsigned CountW     = 5;
    localparam int unsigned WeightW    = 20;
    localparam int unsigned ConsumedW  = 5;

    // Bytes consumed per frame kind.
    localparam logic [ConsumedW-1:0] LEN_NONE  = 5'd0;
    localparam logic [ConsumedW-1:0] LEN_SHORT = 5'd7;
    localparam logic [ConsumedW-1:0] LEN_LONG  = 5'd17;

    // Character codes used by the frame checks.
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h6B;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // One buffered frame, byte 0 at index 0.
    typedef logic [StoreDepth-1:0][7:0] t_frame;

    // Outcome of evaluating one buffer.
    typedef struct packed {
        logic [ConsumedW-1:0] consumed;
        logic                 upd_weight;
        logic [WeightW-1:0]   weight;
        logic                 clr_stable;
    } t_eval;

    // ASCII digit test.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Digit value, widened to the weight width.
    function automatic logic [WeightW-1:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return {{(WeightW-4){1'b0}}, d[3:0]};
    endfunction

endpackage

>>> rtl/core/swfp_capture.sv
// Byte capture: frame store, saturating byte count and the snapshot taken at the end mark.
module swfp_capture
    import swfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    input  logic              i_advance,
    output logic              o_snap_valid,
    output t_frame            o_snap_frame,
    output logic [CountW-1:0] o_snap_count
);

    logic [7:0]        r_store [StoreDepth];
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic              w_room;
    t_frame            n_frame;
    logic              r_snap_valid;
    t_frame            r_snap_frame;
    logic [CountW-1:0] r_snap_count;

    assign w_room = (r_count < CountW'(StoreDepth));

    // Store contents including the word being accepted now.
    always_comb begin
        for (int i = 0; i < StoreDepth; i++) begin
            n_frame[i] = r_store[i];
        end
        if (w_room) begin
            n_frame[r_count] = i_data;
        end
        n_count = w_room ? r_count + CountW'(1) : r_count;
    end

    // Store writes; bytes past the depth are dropped.
    always_ff @(posedge i_clk) begin
        if (i_accept && w_room) begin
            r_store[r_count] <= i_data;
        end
    end

    // Byte count returns to zero after every end mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= i_last ? '0 : n_count;
        end
    end

    // Snapshot of a finished buffer, handed to evaluation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (i_advance) begin
            r_snap_valid <= i_accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_last) begin
            r_snap_frame <= n_frame;
            r_snap_count <= n_count;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap_frame = r_snap_frame;
    assign o_snap_count = r_snap_count;

endmodule

>>> rtl/core/swfp_eval.sv
// Frame evaluation: long text frame first, then the short STX/ETX frame.
module swfp_eval
    import swfp_pkg::*;
(
    input  t_frame            i_frame,
    input  logic [CountW-1:0] i_count,
    output t_eval             o_eval
);

    logic               w_long_hdr;
    logic               w_comma8;
    logic               w_space6;
    logic               w_minus6;
    logic               w_long_digits;
    logic               w_long_ok;
    logic [WeightW-1:0] w_long_val;
    logic               w_short_hdr;
    logic               w_status_ch;
    logic               w_status_ok;
    logic               w_short_digits;
    logic [WeightW-1:0] w_short_val;

    // Long frame: fixed header and unit, six digit places with optional comma and blank or minus sign.
    always_comb begin
        w_long_hdr = (i_count == CountW'(StoreDepth))
            && (i_frame[0] == CH_P) && (i_frame[1] == CH_E)
            && (i_frame[2] == CH_S) && (i_frame[3] == CH_O)
            && (i_frame[13] == CH_K) && (i_frame[14] == CH_G);
        w_comma8 = (i_frame[8] == CH_COMMA);
        w_space6 = (i_frame[6] == CH_SPACE);
        w_minus6 = (i_frame[6] == CH_MINUS);
        w_long_digits = is_digit(i_frame[11]) && is_digit(i_frame[10])
            && is_digit(i_frame[9]) && (w_comma8 || is_digit(i_frame[8]))
            && is_digit(i_frame[7]);
        w_long_ok = w_long_hdr && w_long_digits
            && (w_space6 || w_minus6 || is_digit(i_frame[6]));
        // A skipped comma shifts the upper places down by one decade.
        w_long_val = digit_val(i_frame[11])
            + digit_val(i_frame[10]) * WeightW'(10)
            + digit_val(i_frame[9]) * WeightW'(100)
            + (w_comma8 ? '0 : digit_val(i_frame[8]) * WeightW'(1000))
            + digit_val(i_frame[7]) * (w_comma8 ? WeightW'(1000) : WeightW'(10000))
            + ((w_space6 || w_minus6) ? '0 :
               digit_val(i_frame[6]) * (w_comma8 ? WeightW'(10000) : WeightW'(100000)));
    end

    // Short frame: STX, five places, ETX; a repeated status letter replaces the digits.
    always_comb begin
        w_short_hdr = (i_count >= CountW'(LEN_SHORT))
            && (i_frame[0] == CH_STX) && (i_frame[6] == CH_ETX);
        w_status_ch = (i_frame[1] == CH_I) || (i_frame[1] == CH_N) || (i_frame[1] == CH_S);
        w_status_ok = w_status_ch
            && (i_frame[2] == i_frame[1]) && (i_frame[3] == i_frame[1])
            && (i_frame[4] == i_frame[1]) && (i_frame[5] == i_frame[1]);
        w_short_digits = is_digit(i_frame[1]) && is_digit(i_frame[2])
            && is_digit(i_frame[3]) && is_digit(i_frame[4]) && is_digit(i_frame[5]);
        w_short_val = digit_val(i_frame[5])
            + digit_val(i_frame[4]) * WeightW'(10)
            + digit_val(i_frame[3]) * WeightW'(100)
            + digit_val(i_frame[2]) * WeightW'(1000)
            + digit_val(i_frame[1]) * WeightW'(10000);
    end

    // Pick the outcome in frame priority order.
    always_comb begin
        o_eval = '{consumed: LEN_NONE, upd_weight: 1'b0, weight: w_long_val,
                   clr_stable: 1'b0};
        if (w_long_ok) begin
            o_eval.consumed = LEN_LONG;
            if (w_minus6) begin
                o_eval.clr_stable = 1'b1;
            end else begin
                o_eval.upd_weight = 1'b1;
            end
        end else if (w_short_hdr && w_status_ok) begin
            o_eval.consumed   = LEN_SHORT;
            o_eval.clr_stable = 1'b1;
        end else if (w_short_hdr && w_short_digits) begin
            o_eval.consumed   = LEN_SHORT;
            o_eval.upd_weight = 1'b1;
            o_eval.weight     = w_short_val;
        end
    end

endmodule

>>> rtl/core/scale_weight_frame_parser.sv
// An end-marked byte's result passes the capture snapshot, then the output register.
// Throughput: one byte per cycle unless a stalled output holds a waiting snapshot; these
// two registers form a two-stage pipeline, so a new byte is taken while a result waits.
// Reset (synchronous, active low) clears the byte count, the held weight,
// the held stable flag and both valid flags; the frame store is not cleared.
// Top level of the scale weight frame parser.
module scale_weight_frame_parser
    import swfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [4:0] consumed, [24:5] weight, [25] stable_flag
);

    logic               w_accept;
    logic               w_out_ready;
    logic               w_load;
    logic               w_snap_valid;
    t_frame             w_snap_frame;
    logic [CountW-1:0]  w_snap_count;
    t_eval              w_eval;
    logic [WeightW-1:0] r_held_weight;
    logic               r_held_stable;
    logic [WeightW-1:0] n_held_weight;
    logic               n_held_stable;
    logic               r_out_valid;
    logic [ConsumedW-1:0] r_out_consumed;
    logic [WeightW-1:0] r_out_weight;
    logic               r_out_stable;

    // Pipeline flow control.
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !w_snap_valid || w_out_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_snap_valid && w_out_ready;

    swfp_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_advance    (s_axis_tready),
        .o_snap_valid (w_snap_valid),
        .o_snap_frame (w_snap_frame),
        .o_snap_count (w_snap_count)
    );

    swfp_eval u_eval (
        .i_frame (w_snap_frame),
        .i_count (w_snap_count),
        .o_eval  (w_eval)
    );

    // Held weight and stable flag after this buffer.
    always_comb begin
        n_held_weight = r_held_weight;
        n_held_stable = r_held_stable;
        if (w_eval.upd_weight) begin
            n_held_weight = w_eval.weight;
            n_held_stable = (w_eval.weight != '0);
        end else if (w_eval.clr_stable) begin
            n_held_stable = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_weight <= '0;
            r_held_stable <= 1'b0;
        end else if (w_load) begin
            r_held_weight <= n_held_weight;
            r_held_stable <= n_held_stable;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_consumed <= w_eval.consumed;
            r_out_weight   <= n_held_weight;
            r_out_stable   <= n_held_stable;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_stable, r_out_weight, r_out_consumed};

`ifndef SYNTHESIS
    // Only the three frame lengths can be reported.
    a_consumed_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] == LEN_NONE || m_axis_tdata[4:0] == LEN_SHORT
                           || m_axis_tdata[4:0] == LEN_LONG))
        else $error("consumed holds an unknown frame length");

    // A stable result never carries a zero weight.
    a_stable_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[25]) |-> (m_axis_tdata[24:5] != '0))
        else $error("stable flag set with zero weight");

    // Held state changes only when a result is loaded.
    a_held_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> ($stable(r_held_weight) && $stable(r_held_stable)))
        else $error("held weight changed without a result");
`endif

endmodule

>>> tb/weight_reply_checker.sv
// Checker for the scale weight frame parser: predicts every result word and compares it.
module weight_reply_checker
    import swfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte_data,   // [7:0] data_byte
    input  logic        i_byte_last,   // last_byte
    input  logic        i_word_valid,
    input  logic        i_word_ready,
    input  logic [31:0] i_word_data,   // [4:0] consumed, [24:5] weight, [25] stable_flag
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ReportLimit = 10;

    // One predicted result word.
    typedef struct packed {
        logic [ConsumedW-1:0] consumed;
        logic [WeightW-1:0]   weight;
        logic                 stable;
    } t_reading;

    // Predicted state of the parser.
    logic [7:0]  reply_bytes [StoreDepth];
    int unsigned reply_count;
    logic [WeightW-1:0] scale_weight;
    logic        scale_stable;

    // Readings still waiting for their result word.
    t_reading expected_readings [$];

    // Long text frame: "PESO", six digit places at 6..11, "kg" at 13..14.
    function automatic logic [ConsumedW-1:0] parse_text_frame();
        int unsigned acc;
        int unsigned mult;
        logic [7:0]  c;
        acc  = 0;
        mult = 1;
        if (reply_count < StoreDepth) return LEN_NONE;
        if (reply_bytes[0] != CH_P || reply_bytes[1] != CH_E || reply_bytes[2] != CH_S ||
            reply_bytes[3] != CH_O || reply_bytes[13] != CH_K || reply_bytes[14] != CH_G)
            return LEN_NONE;
        for (int pos = 11; pos >= 6; pos--) begin
            c = reply_bytes[pos];
            // The comma and the leading blank are skipped; the sign aborts the weight.
            if (pos == 8 && c == CH_COMMA) continue;
            if (pos == 6 && c == CH_SPACE) continue;
            if (pos == 6 && c == CH_MINUS) begin
                scale_stable = 1'b0;
                return LEN_LONG;
            end
            if (c < CH_ZERO || c > CH_NINE) return LEN_NONE;
            acc  += mult * (c - CH_ZERO);
            mult *= 10;
        end
        scale_weight = acc[WeightW-1:0];
        scale_stable = (acc != 0);
        return LEN_LONG;
    endfunction

    // Short frame: STX, five digits or one status letter five times, ETX.
    function automatic logic [ConsumedW-1:0] parse_short_frame();
        int unsigned acc;
        int unsigned mult;
        logic [7:0]  c;
        acc  = 0;
        mult = 1;
        if (reply_count < 7) return LEN_NONE;
        if (reply_bytes[0] != CH_STX || reply_bytes[6] != CH_ETX) return LEN_NONE;
        c = reply_bytes[1];
        if (c == CH_I || c == CH_N || c == CH_S) begin
            for (int pos = 2; pos <= 5; pos++) begin
                if (reply_bytes[pos] != c) return LEN_NONE;
            end
            scale_stable = 1'b0;
            return LEN_SHORT;
        end
        for (int pos = 5; pos >= 1; pos--) begin
            c = reply_bytes[pos];
            if (c < CH_ZERO || c > CH_NINE) return LEN_NONE;
            acc  += mult * (c - CH_ZERO);
            mult *= 10;
        end
        scale_weight = acc[WeightW-1:0];
        scale_stable = (acc != 0);
        return LEN_SHORT;
    endfunction

    task automatic note_mismatch(input t_reading want, input t_reading got, input logic orphan);
        o_mismatches++;
        if (o_mismatches <= ReportLimit) begin
            if (orphan)
                $display("result word with none expected: consumed %0d weight %0d stable %0d",
                         got.consumed, got.weight, got.stable);
            else
                $display("reading mismatch: expected consumed %0d weight %0d stable %0d, %s",
                         want.consumed, want.weight, want.stable,
                         $sformatf("got consumed %0d weight %0d stable %0d",
                                   got.consumed, got.weight, got.stable));
        end
    endtask

    // Both channels are sampled at the rising edge; the result side goes first, so a
    // word can never be matched against a reading predicted at the same edge.
    always @(posedge i_clk) begin
        t_reading seen;
        t_reading want;
        logic [ConsumedW-1:0] used;
        if (!i_rst_n) begin
            reply_count  = 0;
            scale_weight = '0;
            scale_stable = 1'b0;
            o_mismatches = 0;
            expected_readings.delete();
        end else begin
            // Result side.
            if (i_word_valid && i_word_ready) begin
                seen.consumed = i_word_data[4:0];
                seen.weight   = i_word_data[24:5];
                seen.stable   = i_word_data[25];
                if (expected_readings.size() == 0) begin
                    note_mismatch(seen, seen, 1'b1);
                end else begin
                    want = expected_readings.pop_front();
                    if (seen.consumed != want.consumed || seen.weight != want.weight ||
                        seen.stable != want.stable)
                        note_mismatch(want, seen, 1'b0);
                end
            end
            // Byte side: store the first bytes, evaluate at the end mark.
            if (i_byte_valid && i_byte_ready) begin
                if (reply_count < StoreDepth) begin
                    reply_bytes[reply_count] = i_byte_data;
                    reply_count++;
                end
                if (i_byte_last) begin
                    used = parse_text_frame();
                    if (used == LEN_NONE) used = parse_short_frame();
                    reply_count = 0;
                    expected_readings.push_back('{used, scale_weight, scale_stable});
                end
            end
        end
        o_outstanding = expected_readings.size();
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the scale weight frame parser: clock, reset, reply stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swfp_pkg::*;

    localparam int CycleLimit   = 100000;
    localparam int PhaseBytes   = 160;
    localparam int SettleCycles = 10;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [4:0] consumed, [24:5] weight, [25] stable_flag

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int send_idle_pct = 12;
    int recv_idle_pct = 50;
    int sent_bytes = 0;

    // Bytes of the reply buffer being built.
    logic [7:0] reply [$];

    scale_weight_frame_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    weight_reply_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (s_axis_tvalid),
        .i_byte_ready  (s_axis_tready),
        .i_byte_data   (s_axis_tdata),
        .i_byte_last   (s_axis_tlast),
        .i_word_valid  (m_axis_tvalid),
        .i_word_ready  (m_axis_tready),
        .i_word_data   (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver back-pressure, one decision per cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] dig(input int n);
        return CH_ZERO + 8'(n);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    // Long text frame with the six weight places given.
    task automatic build_text(input logic [7:0] p6, p7, p8, p9, p10, p11);
        reply.delete();
        reply = {CH_P, CH_E, CH_S, CH_O, CH_SPACE, CH_SPACE, p6, p7, p8, p9, p10, p11,
                 CH_SPACE, CH_K, CH_G, CH_CR, CH_LF};
    endtask

    task automatic build_short(input logic [7:0] p1, p2, p3, p4, p5);
        reply.delete();
        reply = {CH_STX, p1, p2, p3, p4, p5, CH_ETX};
    endtask

    task automatic build_random_text();
        logic [7:0] d [6];
        for (int i = 0; i < 6; i++) d[i] = dig($urandom_range(9));
        if ($urandom_range(7) == 0) begin
            for (int i = 0; i < 6; i++) d[i] = CH_ZERO;
        end
        case ($urandom_range(9))
            0: d[0] = CH_SPACE;
            1: d[0] = CH_MINUS;
            default: ;
        endcase
        if ($urandom_range(3) == 0) d[2] = CH_COMMA;
        build_text(d[0], d[1], d[2], d[3], d[4], d[5]);
        // Places the parser ignores carry random content.
        reply[4]  = any_byte();
        reply[5]  = any_byte();
        reply[12] = any_byte();
        reply[15] = any_byte();
        reply[16] = any_byte();
    endtask

    task automatic build_random_short();
        logic [7:0] d [5];
        logic [7:0] letter;
        for (int i = 0; i < 5; i++) d[i] = dig($urandom_range(9));
        case ($urandom_range(7))
            0, 1: begin
                case ($urandom_range(2))
                    0: letter = CH_I;
                    1: letter = CH_N;
                    default: letter = CH_S;
                endcase
                for (int i = 0; i < 5; i++) d[i] = letter;
            end
            2: for (int i = 0; i < 5; i++) d[i] = CH_ZERO;
            default: ;
        endcase
        build_short(d[0], d[1], d[2], d[3], d[4]);
    endtask

    // Mostly well-formed frames, then damaged, cut, padded and pure noise buffers.
    task automatic build_random_reply();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 35) begin
            build_random_text();
        end else if (kind < 65) begin
            build_random_short();
        end else if (kind < 78) begin
            if ($urandom_range(1) == 0) build_random_text();
            else build_random_short();
            reply[$urandom_range(reply.size() - 1)] = any_byte();
        end else if (kind < 86) begin
            build_random_text();
            n = $urandom_range(10, 1);
            repeat (n) void'(reply.pop_back());
        end else if (kind < 93) begin
            if ($urandom_range(1) == 0) build_random_text();
            else build_random_short();
            n = $urandom_range(8, 1);
            repeat (n) reply.push_back(any_byte());
        end else begin
            reply.delete();
            n = $urandom_range(20, 1);
            repeat (n) reply.push_back(any_byte());
            case ($urandom_range(2))
                0: reply[0] = CH_STX;
                1: reply[0] = CH_P;
                default: ;
            endcase
        end
    endtask

    // Offer one byte; returns at the falling edge after it was taken.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_reply();
        for (int i = 0; i < reply.size(); i++) begin
            send_byte(reply[i], i == reply.size() - 1);
        end
        sent_bytes += reply.size();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed replies: weight extremes and each frame rule.
        build_text(dig(9), dig(9), dig(9), dig(9), dig(9), dig(9)); send_reply();
        build_text(CH_SPACE, dig(1), CH_COMMA, dig(2), dig(3), dig(4)); send_reply();
        build_text(CH_MINUS, dig(0), dig(0), dig(5), dig(0), dig(0)); send_reply();
        build_text(dig(0), dig(0), dig(0), dig(0), dig(0), dig(0)); send_reply();
        build_text(CH_MINUS, dig(1), dig(2), dig(3), CH_ZERO - 8'd1, dig(4)); send_reply();
        build_text(dig(1), dig(2), dig(3), dig(4), dig(5), CH_NINE + 8'd1); send_reply();
        build_text(dig(1), CH_COMMA, dig(3), dig(4), dig(5), dig(6)); send_reply();
        build_text(dig(1), dig(2), CH_SPACE, dig(4), dig(5), dig(6)); send_reply();
        build_short(dig(9), dig(9), dig(9), dig(9), dig(9)); send_reply();
        build_short(dig(0), dig(0), dig(0), dig(0), dig(0)); send_reply();
        build_short(dig(1), dig(2), dig(3), dig(4), dig(5)); send_reply();
        build_short(CH_I, CH_I, CH_I, CH_I, CH_I); send_reply();
        build_short(CH_N, CH_N, CH_N, CH_N, CH_N); send_reply();
        build_short(CH_S, CH_S, CH_S, CH_S, CH_S); send_reply();
        build_short(CH_I, CH_I, CH_N, CH_I, CH_I); send_reply();
        build_short(dig(1), dig(2), CH_ZERO - 8'd1, dig(4), dig(5)); send_reply();
        // A text frame one byte short falls through both checks.
        build_text(dig(1), dig(2), dig(3), dig(4), dig(5), dig(6));
        void'(reply.pop_back());
        send_reply();
        // Bytes past the seventeenth are dropped.
        build_text(dig(7), dig(6), dig(5), dig(4), dig(3), dig(2));
        reply.push_back(8'h00);
        reply.push_back(8'hFF);
        reply.push_back(CH_P);
        reply.push_back(CH_STX);
        send_reply();
        // Short frame at the head of a long buffer.
        build_short(dig(4), dig(0), dig(0), dig(0), dig(1));
        repeat (10) reply.push_back(any_byte());
        send_reply();
        reply.delete(); reply.push_back(8'hFF); send_reply();
        build_short(dig(3), dig(3), dig(3), dig(3), dig(3));
        void'(reply.pop_back());
        send_reply();
        build_text(dig(1), dig(1), dig(1), dig(1), dig(1), dig(1));
        reply[13] = CH_G;
        send_reply();

        // Random replies in three idling phases, draining between them.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 12; recv_idle_pct = 50; end
                1: begin send_idle_pct = 50; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent_bytes = 0;
            while (sent_bytes < PhaseBytes) begin
                build_random_reply();
                send_reply();
            end
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            while (outstanding != 0) @(negedge i_clk);
        end

        repeat (SettleCycles) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
